// ===== hdl/assert_macros.svh =====
// Assertion macros used by the byte group unpacker top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition in the same cycle as its trigger
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a condition in the cycle after its trigger
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bgu_pkg.sv =====
// Types and constants of the byte group unpacker
package bgu_pkg;

    localparam int GROUP_BYTES = 16;
    localparam int MAX_GROUPS  = 16;
    localparam int GROUP_LIMIT = (MAX_GROUPS < 16) ? MAX_GROUPS : 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] MODE_ZERO   = 8'h00;
    localparam logic [7:0] MODE_PACKED = 8'h01;

    localparam logic [1:0] WC_1 = 2'd0;
    localparam logic [1:0] WC_2 = 2'd1;
    localparam logic [1:0] WC_4 = 2'd2;
    localparam logic [1:0] WC_8 = 2'd3;

    typedef enum logic {
        CMD_GROUP,
        CMD_ZEROS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [63:0] low;
        logic [63:0] high;
        logic [3:0]  index;
        logic        last;
        logic        bad;
        logic [4:0]  run_len;
    } cmd_t;

endpackage

// ===== hdl/bgu_queue.sv =====
// Short command queue between the front decoder and the back emitter
module bgu_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bgu_pkg::cmd_t push_cmd,
    input  logic          pop,
    output bgu_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    bgu_pkg::cmd_t                  entry_reg [bgu_pkg::QUEUE_DEPTH];
    logic [bgu_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [bgu_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [bgu_pkg::QUEUE_AW:0]     count_reg;
    logic [bgu_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [bgu_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [bgu_pkg::QUEUE_AW:0]     count_next;

    assign full  = (count_reg == (bgu_pkg::QUEUE_AW + 1)'(bgu_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/bgu_front.sv =====
// Front decoder: takes encoded bytes, tracks the block, builds group and zero-run commands
module bgu_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_data,
    input  logic          byte_valid,
    input  logic [7:0]    in_byte,
    output logic          byte_stall,
    input  logic          q_full,
    output logic          push,
    output bgu_pkg::cmd_t push_cmd
);

    typedef enum logic [1:0] {
        PH_MODE,
        PH_HEADER,
        PH_FIXED,
        PH_ESCAPE
    } phase_t;

    phase_t      phase_reg,      phase_next;
    logic [4:0]  gcount_reg,     gcount_next;
    logic [4:0]  blk_groups_reg, blk_groups_next;
    logic [31:0] wcodes_reg,     wcodes_next;
    logic [2:0]  hdr_seen_reg,   hdr_seen_next;
    logic [3:0]  cur_group_reg,  cur_group_next;
    logic [4:0]  fix_seen_reg,   fix_seen_next;
    logic [15:0] esc_reg,        esc_next;
    logic [7:0]  buf_reg  [bgu_pkg::GROUP_BYTES];
    logic [7:0]  buf_next [bgu_pkg::GROUP_BYTES];

    logic        byte_accept;
    logic [4:0]  groups_clamped;

    assign byte_stall  = q_full;
    assign byte_accept = byte_valid && !q_full;

    always_comb
    begin
        if (gcount_reg == 5'd0)
        begin
            groups_clamped = 5'd1;
        end
        else if (gcount_reg > 5'(bgu_pkg::GROUP_LIMIT))
        begin
            groups_clamped = 5'(bgu_pkg::GROUP_LIMIT);
        end
        else
        begin
            groups_clamped = gcount_reg;
        end
    end

    always_comb
    begin
        logic [1:0] wcode;
        logic [4:0] fix_inc;
        logic [4:0] hdr_need;
        logic [2:0] hdr_inc;
        logic [3:0] pos;
        logic [3:0] esc_pos;
        logic [1:0] v2;
        logic [3:0] v4;
        logic       finish;
        logic       done;
        logic       last;

        phase_next      = phase_reg;
        gcount_next     = gcount_reg;
        blk_groups_next = blk_groups_reg;
        wcodes_next     = wcodes_reg;
        hdr_seen_next   = hdr_seen_reg;
        cur_group_next  = cur_group_reg;
        fix_seen_next   = fix_seen_reg;
        esc_next        = esc_reg;
        buf_next        = buf_reg;
        push            = 1'b0;
        push_cmd        = '0;
        finish          = 1'b0;
        done            = 1'b0;
        last            = 1'b0;
        pos             = '0;
        v2              = '0;
        v4              = '0;

        wcode    = wcodes_reg[{cur_group_reg, 1'b0} +: 2];
        fix_inc  = fix_seen_reg + 5'd1;
        hdr_inc  = hdr_seen_reg + 3'd1;
        hdr_need = (blk_groups_reg + 5'd3) >> 2;

        esc_pos = 4'd15;
        for (int i = 15; i >= 0; i--)
        begin
            if (esc_reg[i])
            begin
                esc_pos = 4'(i);
            end
        end

        if (cfg_we)
        begin
            gcount_next = cfg_data;
        end

        if (byte_accept)
        begin
            case (phase_reg)
                PH_MODE:
                begin
                    if (in_byte == bgu_pkg::MODE_ZERO)
                    begin
                        push             = 1'b1;
                        push_cmd.kind    = bgu_pkg::CMD_ZEROS;
                        push_cmd.run_len = groups_clamped;
                    end
                    else if (in_byte == bgu_pkg::MODE_PACKED)
                    begin
                        blk_groups_next = groups_clamped;
                        wcodes_next     = '0;
                        hdr_seen_next   = '0;
                        cur_group_next  = '0;
                        fix_seen_next   = '0;
                        esc_next        = '0;
                        phase_next      = PH_HEADER;
                    end
                    else
                    begin
                        push          = 1'b1;
                        push_cmd.kind = bgu_pkg::CMD_GROUP;
                        push_cmd.bad  = 1'b1;
                    end
                end
                PH_HEADER:
                begin
                    wcodes_next[{hdr_seen_reg[1:0], 3'b000} +: 8] =
                        wcodes_reg[{hdr_seen_reg[1:0], 3'b000} +: 8] | in_byte;
                    hdr_seen_next = hdr_inc;
                    if ({2'b00, hdr_inc} >= hdr_need)
                    begin
                        fix_seen_next = '0;
                        esc_next      = '0;
                        phase_next    = PH_FIXED;
                    end
                end
                PH_FIXED:
                begin
                    case (wcode)
                        bgu_pkg::WC_8:
                        begin
                            buf_next[fix_seen_reg[3:0]] = in_byte;
                            done = (fix_inc >= 5'd16);
                        end
                        bgu_pkg::WC_4:
                        begin
                            for (int k = 0; k < 2; k++)
                            begin
                                v4  = in_byte[(7 - 4 * k) -: 4];
                                pos = {fix_seen_reg[2:0], 1'(k)};
                                if (v4 == 4'hF)
                                begin
                                    esc_next[pos] = 1'b1;
                                    buf_next[pos] = 8'h00;
                                end
                                else
                                begin
                                    buf_next[pos] = {4'h0, v4};
                                end
                            end
                            done = (fix_inc >= 5'd8);
                        end
                        bgu_pkg::WC_2:
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                v2  = in_byte[(7 - 2 * k) -: 2];
                                pos = {fix_seen_reg[1:0], 2'(k)};
                                if (v2 == 2'b11)
                                begin
                                    esc_next[pos] = 1'b1;
                                    buf_next[pos] = 8'h00;
                                end
                                else
                                begin
                                    buf_next[pos] = {6'h00, v2};
                                end
                            end
                            done = (fix_inc >= 5'd4);
                        end
                        default:
                        begin
                            for (int k = 0; k < 8; k++)
                            begin
                                pos = {fix_seen_reg[0], 3'(k)};
                                esc_next[pos] = esc_reg[pos] | in_byte[7 - k];
                                buf_next[pos] = 8'h00;
                            end
                            done = (fix_inc >= 5'd2);
                        end
                    endcase
                    fix_seen_next = fix_inc;
                    if (done)
                    begin
                        if ((wcode != bgu_pkg::WC_8) && (esc_next != '0))
                        begin
                            phase_next = PH_ESCAPE;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                end
                PH_ESCAPE:
                begin
                    buf_next[esc_pos] = in_byte;
                    esc_next[esc_pos] = 1'b0;
                    if (esc_next == '0)
                    begin
                        finish = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_MODE;
                end
            endcase
        end

        if (finish)
        begin
            last           = ({1'b0, cur_group_reg} + 5'd1 >= blk_groups_reg);
            push           = 1'b1;
            push_cmd.kind  = bgu_pkg::CMD_GROUP;
            push_cmd.index = cur_group_reg;
            push_cmd.last  = last;
            for (int i = 0; i < 8; i++)
            begin
                push_cmd.low[i * 8 +: 8]  = buf_next[i];
                push_cmd.high[i * 8 +: 8] = buf_next[i + 8];
            end
            fix_seen_next = '0;
            esc_next      = '0;
            if (last)
            begin
                cur_group_next = '0;
                phase_next     = PH_MODE;
            end
            else
            begin
                cur_group_next = cur_group_reg + 4'd1;
                phase_next     = PH_FIXED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MODE;
            gcount_reg     <= 5'd16;
            blk_groups_reg <= 5'd16;
            wcodes_reg     <= '0;
            hdr_seen_reg   <= '0;
            cur_group_reg  <= '0;
            fix_seen_reg   <= '0;
            esc_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            gcount_reg     <= gcount_next;
            blk_groups_reg <= blk_groups_next;
            wcodes_reg     <= wcodes_next;
            hdr_seen_reg   <= hdr_seen_next;
            cur_group_reg  <= cur_group_next;
            fix_seen_reg   <= fix_seen_next;
            esc_reg        <= esc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ===== hdl/bgu_back.sv =====
// Back emitter: drains commands, expands zero blocks, holds the output word
module bgu_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  bgu_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          pop,
    output logic          run_busy,
    output logic          group_valid,
    input  logic          group_stall,
    output logic [63:0]   group_low,
    output logic [63:0]   group_high,
    output logic [3:0]    group_index,
    output logic          last_group,
    output logic          bad_mode
);

    logic        valid_reg, valid_next;
    logic [63:0] low_reg,   low_next;
    logic [63:0] high_reg,  high_next;
    logic [3:0]  index_reg, index_next;
    logic        last_reg,  last_next;
    logic        bad_reg,   bad_next;
    logic [4:0]  run_rem_reg, run_rem_next;
    logic [3:0]  run_idx_reg, run_idx_next;
    logic        load;

    assign load     = !valid_reg || !group_stall;
    assign run_busy = (run_rem_reg != '0);
    assign pop      = load && !run_busy && !q_empty;

    always_comb
    begin
        valid_next   = valid_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        index_next   = index_reg;
        last_next    = last_reg;
        bad_next     = bad_reg;
        run_rem_next = run_rem_reg;
        run_idx_next = run_idx_reg;
        if (load)
        begin
            if (run_busy)
            begin
                valid_next   = 1'b1;
                low_next     = '0;
                high_next    = '0;
                index_next   = run_idx_reg;
                last_next    = (run_rem_reg == 5'd1);
                bad_next     = 1'b0;
                run_idx_next = run_idx_reg + 4'd1;
                run_rem_next = run_rem_reg - 5'd1;
            end
            else if (!q_empty)
            begin
                valid_next = 1'b1;
                case (head.kind)
                    bgu_pkg::CMD_ZEROS:
                    begin
                        low_next     = '0;
                        high_next    = '0;
                        index_next   = '0;
                        last_next    = (head.run_len == 5'd1);
                        bad_next     = 1'b0;
                        run_rem_next = head.run_len - 5'd1;
                        run_idx_next = 4'd1;
                    end
                    default:
                    begin
                        low_next   = head.low;
                        high_next  = head.high;
                        index_next = head.index;
                        last_next  = head.last;
                        bad_next   = head.bad;
                    end
                endcase
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            run_rem_reg <= '0;
            run_idx_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            run_rem_reg <= run_rem_next;
            run_idx_reg <= run_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        high_reg  <= high_next;
        index_reg <= index_next;
        last_reg  <= last_next;
        bad_reg   <= bad_next;
    end

    assign group_valid = valid_reg;
    assign group_low   = low_reg;
    assign group_high  = high_reg;
    assign group_index = index_reg;
    assign last_group  = last_reg;
    assign bad_mode    = bad_reg;

endmodule

// ===== hdl/byte_group_unpacker.sv =====
// Byte group unpacker: top level joining front decoder, command queue and back emitter
// One encoded byte is taken every cycle while the two-entry command queue has room.
// Each group of a packed block yields one 16-byte group word on the byte that completes
// it; a mode zero byte yields group_count zero words (clamped to 1..16) from one byte,
// sent by the back emitter at one word per cycle unless the output is stalled, while
// the front keeps taking bytes until the queue fills. A group word goes to a queue entry
// on the edge that takes its last byte, then to the output register when nothing waits
// ahead of it and the output is not stalled. group_count is latched at each mode byte;
// write it only between blocks.
`include "assert_macros.svh"

module byte_group_unpacker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    output logic        group_valid,
    input  logic        group_stall,
    output logic [63:0] group_low,
    output logic [63:0] group_high,
    output logic [3:0]  group_index,
    output logic        last_group,
    output logic        bad_mode
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic          run_busy;
    bgu_pkg::cmd_t q_push_cmd;
    bgu_pkg::cmd_t q_head;
    logic          bad_word_zero;
    logic          run_step;
    logic [3:0]    index_inc;

    bgu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .in_byte    (in_byte),
        .byte_stall (byte_stall),
        .q_full     (q_full),
        .push       (q_push),
        .push_cmd   (q_push_cmd)
    );

    bgu_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    bgu_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .pop         (q_pop),
        .run_busy    (run_busy),
        .group_valid (group_valid),
        .group_stall (group_stall),
        .group_low   (group_low),
        .group_high  (group_high),
        .group_index (group_index),
        .last_group  (last_group),
        .bad_mode    (bad_mode)
    );

    assign bad_word_zero = (group_low == '0) && (group_high == '0) && (group_index == '0)
                           && !last_group;
    assign run_step      = group_valid && !group_stall && run_busy;
    assign index_inc     = group_index + 4'd1;

    `ASSERT_SAME(a_no_push_when_full, q_push, !q_full, "command pushed into a full queue")
    `ASSERT_SAME(a_bad_word_clean, group_valid && bad_mode, bad_word_zero, "bad word has data")
    `ASSERT_NEXT(a_run_step, run_step, group_valid && group_index == $past(index_inc), "run gap")

endmodule

// ===== tb/byte_group_unpacker_tb.sv =====
// Testbench for the byte group unpacker: random and directed byte streams against a predictor
module byte_group_unpacker_tb;

    localparam int CLK_HALF    = 4;
    localparam int SETTLE_WAIT = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;

    typedef enum logic [1:0] {ST_MODE, ST_HEADER, ST_FIXED, ST_ESCAPE} dec_state_t;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
        logic [3:0]  index;
        logic        last;
        logic        bad;
    } group_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  in_byte = '0;
    logic        group_valid;
    logic        group_stall = 1'b0;
    logic [63:0] group_low;
    logic [63:0] group_high;
    logic [3:0]  group_index;
    logic        last_group;
    logic        bad_mode;

    logic [7:0]  bytes_to_send[$];
    group_t      groups_due[$];
    int          errors = 0;
    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;
    int          idle_cycles = 0;

    dec_state_t  st = ST_MODE;
    logic [31:0] wcodes = '0;
    logic [2:0]  hdr_cnt = '0;
    logic [3:0]  grp = '0;
    logic [4:0]  fix_cnt = '0;
    logic [7:0]  grp_bytes [16];
    logic [15:0] esc_mask = '0;
    logic [4:0]  blk_groups = 5'd16;
    logic [4:0]  cfg_groups = 5'd16;

    byte_group_unpacker DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .in_byte     (in_byte),
        .group_valid (group_valid),
        .group_stall (group_stall),
        .group_low   (group_low),
        .group_high  (group_high),
        .group_index (group_index),
        .last_group  (last_group),
        .bad_mode    (bad_mode)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic int effective_groups();
        if (cfg_groups == 0)
            return 1;
        if (cfg_groups > bgu_pkg::GROUP_LIMIT)
            return bgu_pkg::GROUP_LIMIT;
        return int'(cfg_groups);
    endfunction

    function automatic logic [63:0] pack_half(input int base);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
            w[i*8 +: 8] = grp_bytes[base + i];
        return w;
    endfunction

    function automatic void clear_group();
        fix_cnt = '0;
        esc_mask = '0;
        foreach (grp_bytes[i])
            grp_bytes[i] = '0;
    endfunction

    function automatic void close_group();
        group_t g;
        bit     last;
        last = (int'(grp) + 1 >= int'(blk_groups));
        g.low = pack_half(0);
        g.high = pack_half(8);
        g.index = grp;
        g.last = last;
        g.bad = 1'b0;
        groups_due.push_back(g);
        if (last)
        begin
            st = ST_MODE;
            grp = '0;
        end
        else
        begin
            grp = grp + 4'd1;
            st = ST_FIXED;
        end
        clear_group();
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        group_t g;
        int     n;
        int     code;
        int     bits;
        int     per;
        int     sentinel;
        int     v;
        int     pos;
        case (st)
            ST_MODE:
            begin
                n = effective_groups();
                if (b == bgu_pkg::MODE_ZERO)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        g = '0;
                        g.index = 4'(i);
                        g.last = (i + 1 == n);
                        groups_due.push_back(g);
                    end
                end
                else if (b == bgu_pkg::MODE_PACKED)
                begin
                    blk_groups = 5'(n);
                    wcodes = '0;
                    hdr_cnt = '0;
                    grp = '0;
                    clear_group();
                    st = ST_HEADER;
                end
                else
                begin
                    g = '0;
                    g.bad = 1'b1;
                    groups_due.push_back(g);
                end
            end
            ST_HEADER:
            begin
                wcodes = wcodes | (32'(b) << (8 * hdr_cnt[1:0]));
                hdr_cnt = hdr_cnt + 3'd1;
                if (int'(hdr_cnt) >= (int'(blk_groups) + 3) / 4)
                begin
                    clear_group();
                    st = ST_FIXED;
                end
            end
            ST_FIXED:
            begin
                code = int'(wcodes[2*grp +: 2]);
                if (code == bgu_pkg::WC_8)
                begin
                    grp_bytes[fix_cnt[3:0]] = b;
                    fix_cnt = fix_cnt + 5'd1;
                    if (fix_cnt >= bgu_pkg::GROUP_BYTES)
                        close_group();
                end
                else
                begin
                    bits = 1 << code;
                    per = 8 / bits;
                    sentinel = (1 << bits) - 1;
                    for (int k = 0; k < per; k++)
                    begin
                        v = (int'(b) >> (8 - bits * (k + 1))) & sentinel;
                        pos = (int'(fix_cnt) * per + k) & 15;
                        if (v == sentinel)
                        begin
                            esc_mask[pos] = 1'b1;
                            grp_bytes[pos] = '0;
                        end
                        else
                            grp_bytes[pos] = 8'(v);
                    end
                    fix_cnt = fix_cnt + 5'd1;
                    if (int'(fix_cnt) >= bgu_pkg::GROUP_BYTES / per)
                    begin
                        if (esc_mask != 0)
                            st = ST_ESCAPE;
                        else
                            close_group();
                    end
                end
            end
            ST_ESCAPE:
            begin
                if (esc_mask != 0)
                begin
                    pos = 0;
                    while (pos < 15 && !esc_mask[pos])
                        pos++;
                    grp_bytes[pos] = b;
                    esc_mask[pos] = 1'b0;
                end
                if (esc_mask == 0)
                    close_group();
            end
        endcase
    endfunction

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("ERROR %s: expected %h got %h", what, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            in_byte <= '0;
        end
        else if (!byte_valid || !byte_stall)
        begin
            if (bytes_to_send.size() > 0 && $urandom_range(1, 100) > snd_idle_pct)
            begin
                byte_valid <= 1'b1;
                in_byte <= bytes_to_send.pop_front();
            end
            else
                byte_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_stall <= 1'b0;
            hold_cnt <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            group_stall <= 1'b1;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            group_stall <= 1'b1;
        end
        else
            group_stall <= ($urandom_range(1, 100) <= rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
            decode_byte(in_byte);
    end

    always @(posedge clk)
    begin
        group_t g;
        if (rst_n && group_valid && !group_stall)
        begin
            if (groups_due.size() == 0)
                report("group word with none due, index", '0, 64'(group_index));
            else
            begin
                g = groups_due.pop_front();
                if (group_low !== g.low)
                    report("group_low", g.low, group_low);
                if (group_high !== g.high)
                    report("group_high", g.high, group_high);
                if (group_index !== g.index)
                    report("group_index", 64'(g.index), 64'(group_index));
                if (last_group !== g.last)
                    report("last_group", 64'(g.last), 64'(last_group));
                if (bad_mode !== g.bad)
                    report("bad_mode", 64'(g.bad), 64'(bad_mode));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (group_valid && !group_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_quiet();
        @(negedge clk);
        while (bytes_to_send.size() != 0 || byte_valid)
            @(negedge clk);
        while (groups_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic finish_block();
        wait_quiet();
        while (st != ST_MODE)
        begin
            bytes_to_send.push_back(8'h00);
            wait_quiet();
        end
    endtask

    task automatic set_group_count(input logic [4:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        cfg_groups = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                snd_idle_pct = 0;
                rcv_stall_pct = 0;
            end
            1:
            begin
                snd_idle_pct = 65;
                rcv_stall_pct = 0;
            end
            2:
            begin
                snd_idle_pct = 0;
                rcv_stall_pct = 65;
            end
            default:
            begin
                snd_idle_pct = 14;
                rcv_stall_pct = 14;
            end
        endcase
    endtask

    task automatic add_block(input bit broken);
        logic [7:0]  blk[$];
        logic [31:0] codes;
        logic [7:0]  b;
        int          n;
        int          code;
        int          bits;
        int          per;
        int          sentinel;
        int          nesc;
        int          v;
        int          cut;
        n = effective_groups();
        codes = $urandom;
        blk.push_back(bgu_pkg::MODE_PACKED);
        for (int i = 0; i < (n + 3) / 4; i++)
            blk.push_back(codes[8*i +: 8]);
        for (int g = 0; g < n; g++)
        begin
            code = int'(codes[2*g +: 2]);
            if (code == bgu_pkg::WC_8)
            begin
                for (int i = 0; i < bgu_pkg::GROUP_BYTES; i++)
                    blk.push_back(8'($urandom));
            end
            else
            begin
                bits = 1 << code;
                per = 8 / bits;
                sentinel = (1 << bits) - 1;
                nesc = 0;
                for (int f = 0; f < bgu_pkg::GROUP_BYTES / per; f++)
                begin
                    b = '0;
                    for (int k = 0; k < per; k++)
                    begin
                        v = ($urandom_range(0, 3) == 0) ? sentinel : $urandom_range(0, sentinel);
                        if (v == sentinel)
                            nesc++;
                        b = 8'((int'(b) << bits) | v);
                    end
                    blk.push_back(b);
                end
                for (int i = 0; i < nesc; i++)
                    blk.push_back(8'($urandom));
            end
        end
        cut = broken ? $urandom_range(1, blk.size() - 1) : blk.size();
        for (int i = 0; i < cut; i++)
            bytes_to_send.push_back(blk[i]);
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 2))
                0: bytes_to_send.push_back(bgu_pkg::MODE_ZERO);
                1: bytes_to_send.push_back(8'($urandom_range(2, 255)));
                default: bytes_to_send.push_back(8'($urandom));
            endcase
        end
    endtask

    task automatic fill_stream(input int budget);
        int start;
        int pick;
        start = bytes_to_send.size();
        while (bytes_to_send.size() - start < budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                add_noise();
            else
                add_block(pick == 1);
        end
    endtask

    initial
    begin
        int cfg_list [8];
        cfg_list = '{1, 4, 17, 2, 0, 3, 5, 2};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(0);
        bytes_to_send.push_back(bgu_pkg::MODE_ZERO);
        bytes_to_send.push_back(8'h02);
        bytes_to_send.push_back(8'hFF);
        wait_quiet();

        set_group_count(5'd2);
        bytes_to_send.push_back(bgu_pkg::MODE_PACKED);
        bytes_to_send.push_back(8'h05);
        wait_quiet();
        // count change lands mid-block, must only apply from the next mode byte
        set_group_count(5'd0);
        bytes_to_send.push_back(8'h1B);
        bytes_to_send.push_back(8'hE4);
        bytes_to_send.push_back(8'h55);
        bytes_to_send.push_back(8'hAA);
        bytes_to_send.push_back(8'h80);
        bytes_to_send.push_back(8'h01);
        repeat (4) bytes_to_send.push_back(8'h00);
        bytes_to_send.push_back(bgu_pkg::MODE_ZERO);
        wait_quiet();

        set_group_count(5'd31);
        bytes_to_send.push_back(bgu_pkg::MODE_ZERO);
        bytes_to_send.push_back(8'h80);
        wait_quiet();

        foreach (cfg_list[i])
        begin
            set_idling(i % 4);
            finish_block();
            set_group_count(5'(cfg_list[i]));
            if (i == 0)
            begin
                hold_req++;
                repeat (6) bytes_to_send.push_back(bgu_pkg::MODE_ZERO);
            end
            fill_stream(28);
            wait_quiet();
        end

        wait_quiet();
        repeat (20) @(posedge clk);
        if (groups_due.size() != 0)
            report("group words never delivered, count", '0, 64'(groups_due.size()));
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bgu_pkg.sv
hdl/bgu_queue.sv
hdl/bgu_front.sv
hdl/bgu_back.sv
hdl/byte_group_unpacker.sv
tb/byte_group_unpacker_tb.sv
